FILE: sv/spl_pkg.sv
// spl_pkg: shared widths, register codes, constants, divider request types
// and the gain saturation helper for the stereo peak limiter.
// No dependencies.
package spl_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int ENV_W           = 32;   // envelope, Q1.31
	localparam int GAIN_W          = 25;   // gain and slope, signed Q2.23
	localparam int LIMIT_W         = 23;
	localparam int TC_W            = 20;   // attack / release divisors
	localparam int SLEW_W          = 27;   // headroom for slew arithmetic
	localparam int CNT_W           = 6;    // divider step counter
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 23;

	localparam logic [LIMIT_W-1:0] LIMIT_RST   = 23'd8388607;
	localparam logic [TC_W-1:0]    ATTACK_RST  = 20'd96;
	localparam logic [TC_W-1:0]    RELEASE_RST = 20'd4800;

	localparam logic signed [GAIN_W-1:0] GAIN_ONE  = 25'sd8388608;
	localparam logic signed [SLEW_W-1:0] MAX_SLEW  = 27'sd41943;   // 0.005 in Q2.23
	localparam logic signed [SLEW_W-1:0] G25_MAX   = 27'sd16777215;
	localparam logic signed [SLEW_W-1:0] G25_MIN   = -27'sd16777216;

	// division lengths: envelope quotient is 32 bits, target is below 2^24
	localparam logic [CNT_W-1:0] ENV_STEPS = 6'd32;
	localparam logic [CNT_W-1:0] TGT_STEPS = 6'd24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIMIT   = 2'd0,
		REG_ATTACK  = 2'd1,
		REG_RELEASE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] steps;
		logic [ENV_W-1:0] rem_init;
		logic [ENV_W-1:0] num_init;
		logic [ENV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [ENV_W-1:0] quot;
	} div_rsp_t;

	// clamp to the signed 25-bit gain range
	function automatic logic signed [GAIN_W-1:0] sat_gain(input logic signed [SLEW_W-1:0] v);
		logic signed [GAIN_W-1:0] r;
		if (v > G25_MAX) begin
			r = G25_MAX[GAIN_W-1:0];
		end else if (v < G25_MIN) begin
			r = G25_MIN[GAIN_W-1:0];
		end else begin
			r = v[GAIN_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: sv/spl_if.sv
// spl_if: valid/ready channel interfaces for samples, results and register writes.
// Depends on spl_pkg for widths.
interface spl_sample_if #(parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;
	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface spl_result_if #(parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF);
	logic                                 valid;
	logic                                 ready;
	logic signed [SAMPLE_BITS-1:0]        left_out;
	logic signed [SAMPLE_BITS-1:0]        right_out;
	logic signed [spl_pkg::GAIN_W-1:0]    gain_out;
	modport source (output valid, output left_out, output right_out, output gain_out,
		input ready);
	modport sink (input valid, input left_out, input right_out, input gain_out,
		output ready);
endinterface

interface spl_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [spl_pkg::CFG_IDX_W-1:0]   index;
	logic [spl_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/spl_divider.sv
// spl_divider: shared restoring divider, one quotient bit per cycle.
// Depends on spl_pkg (div_req_t, div_rsp_t, widths).
module spl_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  spl_pkg::div_req_t req,
	output spl_pkg::div_rsp_t rsp
);
	localparam int W = spl_pkg::ENV_W;

	logic                      busy_q;
	logic                      done_q;
	logic [spl_pkg::CNT_W-1:0] cnt_q;
	logic [W-1:0]              rem_q;
	logic [W-1:0]              num_q;
	logic [W-1:0]              quo_q;
	logic [W-1:0]              dvs_q;

	logic [W:0]   shifted;
	logic [W+1:0] trial;
	logic         fits;

	// trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		shifted = {rem_q, num_q[W-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
		fits    = ~trial[W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
				rem_q  <= req.rem_init;
				num_q  <= req.num_init;
				dvs_q  <= req.divisor;
				quo_q  <= '0;
			end else if (busy_q) begin
				rem_q <= fits ? trial[W-1:0] : shifted[W-1:0];
				num_q <= {num_q[W-2:0], 1'b0};
				quo_q <= {quo_q[W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == spl_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

FILE: sv/spl_mult.sv
// spl_mult: sample times gain with a registered product, then rounding to
// nearest (ties up) and saturation to the sample width. Depends on spl_pkg.
module spl_mult #(
	parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic signed [spl_pkg::GAIN_W-1:0] gain,
	output logic signed [SAMPLE_BITS-1:0]     scaled
);
	localparam int PW = SAMPLE_BITS + spl_pkg::GAIN_W;
	localparam int QW = PW + 1 - 23;
	localparam logic signed [QW-1:0] HI = QW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [QW-1:0] LO = -HI - QW'(1);

	logic signed [PW-1:0] prod_s1;
	logic signed [PW:0]   biased;
	logic signed [QW-1:0] quot;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(sample) * PW'(gain);
		end
	end

	// add half an LSB of Q2.23, floor-shift, clamp
	always_comb begin
		biased = (PW + 1)'(prod_s1) + (PW + 1)'(64'sd4194304);
		quot   = QW'(biased >>> 23);
		if (quot > HI) begin
			scaled = HI[SAMPLE_BITS-1:0];
		end else if (quot < LO) begin
			scaled = LO[SAMPLE_BITS-1:0];
		end else begin
			scaled = quot[SAMPLE_BITS-1:0];
		end
	end

endmodule

FILE: sv/stereo_peak_limiter.sv
// stereo_peak_limiter: top level, register file, sequencer, envelope and gain slew.
// Depends on spl_pkg, spl_if, spl_divider, spl_mult.
//
//   channel   dir   payload                               role
//   samples   in    left_sample, right_sample             one stereo pair per request
//   results   out   left_out, right_out, gain_out         one result per request
//   cfg       in    index, data                           register write, always ready
//
// One pair is in work at a time; samples.ready is high only while the sequencer idles.
// The result goes through the envelope divider start, the 32-step envelope division,
// then, only when the envelope ends above the limit, the gain divider start and the
// 24-step gain division, then the slew step, the left and right passes on the shared
// multiplier and the output write. The next request is taken once the sequencer is
// back in idle.
// A finished result sits in the output register; the next pair is taken meanwhile,
// and a stalled result holds only the final write of the following one.
// Reset puts the envelope at zero, gain at one, slope at zero, registers at defaults.
module stereo_peak_limiter #(
	parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	spl_sample_if.sink    samples,
	spl_result_if.source  results,
	spl_cfg_if.sink       cfg
);
	localparam int EW = spl_pkg::ENV_W;
	localparam int GW = spl_pkg::GAIN_W;
	localparam int SW = spl_pkg::SLEW_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENV_START,
		ST_ENV_WAIT,
		ST_TGT_START,
		ST_TGT_WAIT,
		ST_SLEW,
		ST_MUL_L,
		ST_MUL_R,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [spl_pkg::LIMIT_W-1:0] limit_q;
	logic [spl_pkg::TC_W-1:0]    attack_q;
	logic [spl_pkg::TC_W-1:0]    release_q;

	logic [EW-1:0]                envelope_q;
	logic signed [GW-1:0]         gain_q;
	logic signed [GW-1:0]         slope_q;
	logic signed [GW-1:0]         target_q;
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [SAMPLE_BITS-1:0] right_q;
	logic signed [SAMPLE_BITS-1:0] left_res_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_left_q;
	logic signed [SAMPLE_BITS-1:0] out_right_q;
	logic signed [GW-1:0]          out_gain_q;

	spl_pkg::div_req_t div_req;
	spl_pkg::div_rsp_t div_rsp;

	logic [SAMPLE_BITS-1:0] mag_l;
	logic [SAMPLE_BITS-1:0] mag_r;
	logic [EW-1:0]          peak;
	logic                   rising;
	logic [EW-1:0]          env_diff;
	logic [EW-1:0]          env_next;
	logic [EW-1:0]          limit_env;
	logic [spl_pkg::TC_W-1:0] tc_eff;

	logic signed [SW-1:0] step;
	logic signed [SW-1:0] lo_bound;
	logic signed [SW-1:0] hi_bound;
	logic signed [GW-1:0] step_sat;
	logic signed [SW-1:0] gain_next;

	logic                          mul_en;
	logic signed [SAMPLE_BITS-1:0] mul_sample;
	logic signed [SAMPLE_BITS-1:0] mul_res;
	logic                          out_free;

	// register writes; unknown index is dropped
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= spl_pkg::LIMIT_RST;
			attack_q  <= spl_pkg::ATTACK_RST;
			release_q <= spl_pkg::RELEASE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				spl_pkg::REG_LIMIT:   limit_q   <= cfg.data[spl_pkg::LIMIT_W-1:0];
				spl_pkg::REG_ATTACK:  attack_q  <= cfg.data[spl_pkg::TC_W-1:0];
				spl_pkg::REG_RELEASE: release_q <= cfg.data[spl_pkg::TC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// peak and envelope step; most negative sample keeps magnitude 2^(N-1)
	always_comb begin
		mag_l     = left_q[SAMPLE_BITS-1] ? (~$unsigned(left_q) + 1'b1) : $unsigned(left_q);
		mag_r     = right_q[SAMPLE_BITS-1] ? (~$unsigned(right_q) + 1'b1) : $unsigned(right_q);
		peak      = EW'(mag_l > mag_r ? mag_l : mag_r) << (EW - SAMPLE_BITS);
		rising    = peak > envelope_q;
		env_diff  = rising ? (peak - envelope_q) : (envelope_q - peak);
		env_next  = rising ? (envelope_q + div_rsp.quot) : (envelope_q - div_rsp.quot);
		limit_env = {1'b0, limit_q, 8'd0};
		tc_eff    = rising ? attack_q : release_q;
		if (tc_eff == '0) begin
			tc_eff = spl_pkg::TC_W'(1);
		end
	end

	// divider requests
	always_comb begin
		div_req = '0;
		if (state_q == ST_ENV_START) begin
			div_req.start    = 1'b1;
			div_req.steps    = spl_pkg::ENV_STEPS;
			div_req.rem_init = '0;
			div_req.num_init = env_diff;
			div_req.divisor  = EW'(tc_eff);
		end else if (state_q == ST_TGT_START) begin
			// limit * 2^31 / envelope; quotient fits in 24 bits
			div_req.start    = 1'b1;
			div_req.steps    = spl_pkg::TGT_STEPS;
			div_req.rem_init = {2'b00, limit_q, 7'd0};
			div_req.num_init = '0;
			div_req.divisor  = envelope_q;
		end
	end

	spl_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// gain slew: slope may change by at most MAX_SLEW per pair
	always_comb begin
		step     = SW'(target_q) - SW'(gain_q);
		lo_bound = SW'(slope_q) - spl_pkg::MAX_SLEW;
		hi_bound = SW'(slope_q) + spl_pkg::MAX_SLEW;
		if (step < lo_bound) begin
			step_sat  = spl_pkg::sat_gain(lo_bound);
			gain_next = SW'(gain_q) + SW'(step_sat);
		end else if (step > hi_bound) begin
			step_sat  = spl_pkg::sat_gain(hi_bound);
			gain_next = SW'(gain_q) + SW'(step_sat);
		end else begin
			step_sat  = spl_pkg::sat_gain(step);
			gain_next = SW'(target_q);
		end
	end

	// shared multiplier, left then right
	assign mul_en     = (state_q == ST_MUL_L) || (state_q == ST_MUL_R);
	assign mul_sample = (state_q == ST_MUL_L) ? left_q : right_q;

	spl_mult #(.SAMPLE_BITS(SAMPLE_BITS)) u_mult (
		.clk    (clk),
		.en     (mul_en),
		.sample (mul_sample),
		.gain   (gain_q),
		.scaled (mul_res)
	);

	assign out_free      = !out_valid_q || results.ready;
	assign samples.ready = (state_q == ST_IDLE);

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			envelope_q  <= '0;
			gain_q      <= spl_pkg::GAIN_ONE;
			slope_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result valid: set on the final write, cleared once taken
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						left_q  <= samples.left_sample;
						right_q <= samples.right_sample;
						state_q <= ST_ENV_START;
					end
				end
				ST_ENV_START: begin
					state_q <= ST_ENV_WAIT;
				end
				ST_ENV_WAIT: begin
					if (div_rsp.done) begin
						envelope_q <= env_next;
						if (env_next > limit_env) begin
							state_q <= ST_TGT_START;
						end else begin
							target_q <= spl_pkg::GAIN_ONE;
							state_q  <= ST_SLEW;
						end
					end
				end
				ST_TGT_START: begin
					state_q <= ST_TGT_WAIT;
				end
				ST_TGT_WAIT: begin
					if (div_rsp.done) begin
						target_q <= $signed({1'b0, div_rsp.quot[GW-2:0]});
						state_q  <= ST_SLEW;
					end
				end
				ST_SLEW: begin
					slope_q <= step_sat;
					gain_q  <= spl_pkg::sat_gain(gain_next);
					state_q <= ST_MUL_L;
				end
				ST_MUL_L: begin
					state_q <= ST_MUL_R;
				end
				ST_MUL_R: begin
					left_res_q <= mul_res;
					state_q    <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_left_q  <= left_res_q;
						out_right_q <= mul_res;
						out_gain_q  <= gain_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid     = out_valid_q;
	assign results.left_out  = out_left_q;
	assign results.right_out = out_right_q;
	assign results.gain_out  = out_gain_q;

endmodule

FILE: sv/spl_checker.sv
// spl_checker: port-level assertions for stereo_peak_limiter, attached by bind.
// Depends on spl_pkg for widths.
module spl_checker #(
	parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [SAMPLE_BITS-1:0]     left_out,
	input logic signed [SAMPLE_BITS-1:0]     right_out,
	input logic signed [spl_pkg::GAIN_W-1:0] gain_out
);

	// a result waits until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(left_out) && $stable(right_out) && $stable(gain_out))
		else $error("stalled result changed");

	// one pair at a time: ready drops after a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

	// no result can appear the cycle after a request
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result came too early");

endmodule

bind stereo_peak_limiter spl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_spl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.left_out  (results.left_out),
	.right_out (results.right_out),
	.gain_out  (results.gain_out)
);
